// ----- hw/rtl/cdts_pkg.sv -----
// Shared types and constants for the crawl-delay text scanner.
// Holds tag strings, byte codes, register indexes and the line state types.
// No dependencies.
package cdts_pkg;

  // Line window depth and its fill counter width
  localparam int WINDOW = 16;
  localparam int FILL_W = 5;

  // Tag strings, last byte of the tag in bits 7:0
  localparam int UA_LEN = 11;
  localparam int CD_LEN = 12;
  localparam logic [8*UA_LEN-1:0] UA_TAG = "User-agent:";
  localparam logic [8*CD_LEN-1:0] CD_TAG = "Crawl-delay:";

  // Byte codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_AGENT_LOW  = 2'd0;
  localparam cfg_index_t CFG_AGENT_HIGH = 2'd1;
  localparam cfg_index_t CFG_AGENT_LEN  = 2'd2;

  // Progress of the number parse on the current line
  typedef enum logic [1:0] {
    PH_COLON = 2'd0,
    PH_BLANK = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  // Per-line flags
  typedef struct packed {
    logic ua;
    logic cd;
    logic agent;
    logic star;
  } line_flags_t;

  // Whitespace skipped before the delay digits
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

endpackage

// ----- hw/rtl/crawl_delay_text_scanner_top.sv -----
// Crawl-delay text scanner, top level.
// Depends on cdts_pkg for tag strings, byte codes and line state types.
//
// Usage:
//   Input channel (in_valid/in_ready) moves one item per cycle when no final
//   byte stalls: a byte of robots text and an end-of-file mark on the last.
//   Result channel (out_valid/out_ready) carries one item per file, issued
//   for the byte marked end_of_file: the largest crawl delay that applies
//   to the configured agent, zero if none.
//   Configuration (cfg_we/cfg_index/cfg_wdata) sets the agent string and
//   its length; write it only while no file is in flight.
// Timing:
//   An accepted item sits in the input register while the window compare,
//   number parse and maximum update run; a result is registered when its
//   final byte leaves the input register. Throughput is one item per cycle,
//   set by the single state update per byte, unless a final byte waits.
// Reset clears the line state, the applies flag, the held maximum and the
//   agent registers. While a result waits on out_ready, further bytes of the
//   next file keep flowing; only a second final byte waits for the slot.
module crawl_delay_text_scanner_top #(
  parameter int MAX_AGENT_CHARS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_end_of_file,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_delay_seconds,
  input  logic                  cfg_we,
  input  cdts_pkg::cfg_index_t  cfg_index,
  input  logic [63:0]           cfg_wdata
);
  import cdts_pkg::*;

  localparam int LEN_W = $clog2(MAX_AGENT_CHARS + 1);

  // Configuration registers
  logic [63:0] agent_low_r;
  logic [63:0] agent_high_r;
  logic [4:0]  agent_len_r;

  // Input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eof_r;

  // Scanner state
  logic [7:0]        win_r [WINDOW];
  logic [FILL_W-1:0] fill_r;
  line_flags_t       flags_r;
  logic              rules_apply_r;
  logic [31:0]       largest_r;
  phase_t            phase_r;
  logic [31:0]       num_val_r;
  logic              num_ovf_r;

  // Result register
  logic        out_valid_r;
  logic [31:0] out_delay_r;

  // Next values
  logic [7:0]        win_nxt [WINDOW];
  logic [FILL_W-1:0] fill_nxt;
  line_flags_t       flags_nxt;
  logic              rules_apply_nxt;
  logic [31:0]       largest_nxt;
  phase_t            phase_nxt;
  logic [31:0]       num_val_nxt;
  logic              num_ovf_nxt;

  // Working signals
  logic                        fire;
  logic                        is_nl;
  logic [LEN_W-1:0]            len_used;
  logic [127:0]                agent_bytes;
  logic [MAX_AGENT_CHARS:0]    agent_match;
  logic                        ua_hit;
  logic                        cd_hit;
  logic                        agent_hit;
  line_flags_t                 flags_tb;
  phase_t                      phase_tb;
  logic [31:0]                 num_val_tb;
  logic                        num_ovf_tb;
  logic [35:0]                 num_prod;
  line_flags_t                 end_flags;
  logic [31:0]                 end_val;
  logic                        end_ovf;
  logic [31:0]                 end_delay;
  logic                        end_rules;
  logic [31:0]                 end_largest;

  // Handshake: a final byte needs a free result slot
  assign fire     = s1_valid_r && (!s1_eof_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  assign out_valid         = out_valid_r;
  assign out_delay_seconds = out_delay_r;

  assign is_nl       = (s1_byte_r == CH_NL);
  assign agent_bytes = {agent_high_r, agent_low_r};
  assign len_used    = (agent_len_r > 5'(MAX_AGENT_CHARS)) ? LEN_W'(MAX_AGENT_CHARS)
                                                           : agent_len_r[LEN_W-1:0];

  // Shift the new byte into the window, newest first
  always_comb begin
    win_nxt[0] = s1_byte_r;
    for (int i = 1; i < WINDOW; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    fill_nxt = (fill_r == FILL_W'(WINDOW)) ? fill_r : fill_r + 1'b1;
  end

  // Compare the window tail against both tags and every agent length
  always_comb begin
    ua_hit = (fill_nxt >= FILL_W'(UA_LEN));
    for (int j = 0; j < UA_LEN; j++) begin
      if (win_nxt[j] != UA_TAG[8*j +: 8]) ua_hit = 1'b0;
    end
    cd_hit = (fill_nxt >= FILL_W'(CD_LEN));
    for (int j = 0; j < CD_LEN; j++) begin
      if (win_nxt[j] != CD_TAG[8*j +: 8]) cd_hit = 1'b0;
    end
    agent_match[0] = 1'b0;
    for (int l = 1; l <= MAX_AGENT_CHARS; l++) begin
      agent_match[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win_nxt[l-1-i] != agent_bytes[8*i +: 8]) agent_match[l] = 1'b0;
      end
    end
    agent_hit = (len_used != '0) && (fill_nxt >= FILL_W'(len_used)) &&
                agent_match[len_used];
  end

  // Flags and number parse after taking the byte
  assign num_prod = {1'b0, num_val_r, 3'b000} + {3'b000, num_val_r, 1'b0} +
                    {32'd0, s1_byte_r[3:0]};

  always_comb begin
    flags_tb.ua    = flags_r.ua    | ua_hit;
    flags_tb.cd    = flags_r.cd    | cd_hit;
    flags_tb.agent = flags_r.agent | agent_hit;
    flags_tb.star  = flags_r.star  | (s1_byte_r == CH_STAR);
    phase_tb   = phase_r;
    num_val_tb = num_val_r;
    num_ovf_tb = num_ovf_r;
    case (phase_r)
      PH_COLON: begin
        if (s1_byte_r == CH_COLON) phase_tb = PH_BLANK;
      end
      PH_BLANK, PH_DIGIT: begin
        if (s1_byte_r >= CH_ZERO && s1_byte_r <= CH_NINE) begin
          num_val_tb = num_prod[31:0];
          num_ovf_tb = num_ovf_r | (num_prod[35:32] != 4'd0);
          phase_tb   = PH_DIGIT;
        end else if (phase_r == PH_BLANK && is_blank(s1_byte_r)) begin
          phase_tb = PH_BLANK;
        end else begin
          phase_tb = PH_DONE;
        end
      end
      default: begin
        phase_tb = phase_r;
      end
    endcase
  end

  // Close the line: a newline closes the line as it stood before it
  always_comb begin
    end_flags   = is_nl ? flags_r   : flags_tb;
    end_val     = is_nl ? num_val_r : num_val_tb;
    end_ovf     = is_nl ? num_ovf_r : num_ovf_tb;
    end_delay   = end_ovf ? 32'd0 : end_val;
    end_rules   = rules_apply_r;
    end_largest = largest_r;
    if (end_flags.ua) begin
      end_rules = (len_used == '0) || end_flags.agent || end_flags.star;
    end else if (rules_apply_r && end_flags.cd) begin
      if (end_delay > largest_r) end_largest = end_delay;
    end
  end

  // Choose the next state: file end, line end or plain byte
  always_comb begin
    flags_nxt       = flags_tb;
    phase_nxt       = phase_tb;
    num_val_nxt     = num_val_tb;
    num_ovf_nxt     = num_ovf_tb;
    rules_apply_nxt = rules_apply_r;
    largest_nxt     = largest_r;
    if (s1_eof_r || is_nl) begin
      flags_nxt       = '0;
      phase_nxt       = PH_COLON;
      num_val_nxt     = 32'd0;
      num_ovf_nxt     = 1'b0;
      rules_apply_nxt = s1_eof_r ? 1'b0  : end_rules;
      largest_nxt     = s1_eof_r ? 32'd0 : end_largest;
    end
  end

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_low_r  <= 64'd0;
      agent_high_r <= 64'd0;
      agent_len_r  <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AGENT_LOW:  agent_low_r  <= cfg_wdata;
        CFG_AGENT_HIGH: agent_high_r <= cfg_wdata;
        CFG_AGENT_LEN:  agent_len_r  <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // Capture each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_eof_r  <= in_end_of_file;
    end
  end

  // Advance the scanner state; window bytes past the fill count are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      flags_r       <= '0;
      rules_apply_r <= 1'b0;
      largest_r     <= 32'd0;
      phase_r       <= PH_COLON;
      num_val_r     <= 32'd0;
      num_ovf_r     <= 1'b0;
    end else if (fire) begin
      fill_r        <= (s1_eof_r || is_nl) ? '0 : fill_nxt;
      flags_r       <= flags_nxt;
      rules_apply_r <= rules_apply_nxt;
      largest_r     <= largest_nxt;
      phase_r       <= phase_nxt;
      num_val_r     <= num_val_nxt;
      num_ovf_r     <= num_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_nl) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s1_eof_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_eof_r) begin
      out_delay_r <= end_largest;
    end
  end

  // A final byte leaves the scanner cleared and a result pending
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_eof_r |=> out_valid_r && fill_r == '0 && !rules_apply_r &&
                         largest_r == 32'd0 && phase_r == PH_COLON)
    else $error("scanner not cleared after final byte");

  // A result appears only after a final byte was processed
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && s1_eof_r))
    else $error("result without a final byte");

  // The parse waits for a colon while none arrives
  a_colon_wait: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_COLON && s1_byte_r != CH_COLON |=> phase_r == PH_COLON)
    else $error("number parse started without a colon");

  // The held maximum never falls within a file
  a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1_eof_r |=> largest_r >= $past(largest_r))
    else $error("held delay decreased mid-file");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for crawl_delay_text_scanner_top: streams robots text files and checks
// the largest crawl delay reported per file against a line-by-line scan model.
// Depends on cdts_pkg for tag strings, byte codes, register indexes and line types.
module tb_top;
  import cdts_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 600;
  localparam int MIN_FILES = 40;
  localparam int FILES_PER_PHASE = 3;
  localparam int MIN_PHASES = 8;
  localparam int PAT_W = 8 * WINDOW;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = '0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_delay_seconds;
  logic        cfg_we = 1'b0;
  cfg_index_t  cfg_index = CFG_AGENT_LOW;
  logic [63:0] cfg_wdata = '0;

  crawl_delay_text_scanner_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_delay_seconds(out_delay_seconds),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop if the scanner hangs
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Scan model state and its copy of the agent registers
  logic [63:0]  agent_lo = '0;
  logic [63:0]  agent_hi = '0;
  logic [4:0]   agent_len = '0;
  logic [7:0]   win [WINDOW];
  int unsigned  win_fill;
  line_flags_t  flags;
  phase_t       phase;
  logic [31:0]  num_val;
  logic         num_ovf;
  logic         applies = 1'b0;
  logic [31:0]  max_delay = '0;

  logic [31:0]  pending_delays [$];
  int unsigned  mismatches = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  send_pace = 0;
  bit           hold_request = 1'b0;
  logic [7:0]   file_bytes [$];

  function automatic int unsigned agent_used();
    return (agent_len > 5'd16) ? 16 : agent_len;
  endfunction

  function automatic logic [7:0] agent_char(input int unsigned i);
    return (i < 8) ? agent_lo[8*i +: 8] : agent_hi[8*(i-8) +: 8];
  endfunction

  // Newest window byte lines up with pattern byte 0
  function automatic bit tail_matches(input logic [8*WINDOW-1:0] pat, input int unsigned n);
    if (win_fill < n) return 1'b0;
    for (int k = 0; k < n; k++)
      if (win[k] != pat[8*k +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_line();
    foreach (win[i]) win[i] = '0;
    win_fill = 0;
    flags = '0;
    phase = PH_COLON;
    num_val = '0;
    num_ovf = 1'b0;
  endfunction

  // Settle the applies flag or fold a delay into the maximum
  function automatic void close_line();
    logic [31:0] d;
    if (flags.ua) begin
      applies = (agent_used() == 0) || flags.agent || flags.star;
    end else if (applies && flags.cd) begin
      d = num_ovf ? 32'd0 : num_val;
      if (d > max_delay) max_delay = d;
    end
    clear_line();
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic eof,
                                    output bit has, output logic [31:0] val);
    logic [8*WINDOW-1:0] pat;
    logic [35:0] wide;
    int unsigned n;
    has = 1'b0;
    val = '0;
    if (b == CH_NL) begin
      close_line();
    end else begin
      for (int i = WINDOW - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (win_fill < WINDOW) win_fill++;
      n = agent_used();
      pat = '0;
      for (int k = 0; k < n; k++) pat[8*k +: 8] = agent_char(n - 1 - k);
      if (tail_matches(PAT_W'(UA_TAG), UA_LEN)) flags.ua = 1'b1;
      if (tail_matches(PAT_W'(CD_TAG), CD_LEN)) flags.cd = 1'b1;
      if (n > 0 && tail_matches(pat, n)) flags.agent = 1'b1;
      if (b == CH_STAR) flags.star = 1'b1;
      // Number after the first colon: blanks, then digits
      case (phase)
        PH_COLON: begin
          if (b == CH_COLON) phase = PH_BLANK;
        end
        PH_BLANK, PH_DIGIT: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            wide = {4'd0, num_val} * 36'd10 + {28'd0, b - CH_ZERO};
            if (wide > 36'hFFFF_FFFF) num_ovf = 1'b1;
            num_val = wide[31:0];
            phase = PH_DIGIT;
          end else if (!(phase == PH_BLANK && (b == CH_SPACE || b == CH_TAB ||
                         b == CH_VT || b == CH_FF || b == CH_CR))) begin
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
      if (eof) close_line();
    end
    if (eof) begin
      has = 1'b1;
      val = max_delay;
      clear_line();
      applies = 1'b0;
      max_delay = '0;
    end
  endfunction

  function automatic int unsigned send_gap();
    case (send_pace)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Offer one item, hold it until taken, return on the accepting edge
  task automatic offer_byte(input logic [7:0] b, input logic eof,
                            input bit known, input logic [31:0] known_delay);
    int unsigned gap;
    bit has;
    logic [31:0] val;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_file <= eof;
    do @(negedge clk); while (!in_ready);
    scan_byte(b, eof, has, val);
    if (has) pending_delays.push_back(known ? known_delay : val);
    bytes_sent++;
    @(posedge clk);
  endtask

  // Stop offering and wait until every delay is back and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_delays.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_agent(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AGENT_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_AGENT_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_AGENT_LEN;
    cfg_wdata <= {59'd0, len};
    @(posedge clk);
    cfg_we <= 1'b0;
    agent_lo = lo;
    agent_hi = hi;
    agent_len = len;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  task automatic add_agent_name(input int unsigned cut);
    for (int i = 0; i + cut < agent_used(); i++) file_bytes.push_back(agent_char(i));
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: file_bytes.push_back(CH_SPACE);
        1: file_bytes.push_back(CH_TAB);
        2: file_bytes.push_back(CH_VT);
        3: file_bytes.push_back(CH_FF);
        default: file_bytes.push_back(CH_CR);
      endcase
    end
  endtask

  task automatic add_number();
    logic [63:0] big;
    case ($urandom_range(0, 9))
      0, 1, 2: add_text($sformatf("%0d", $urandom_range(0, 999)));
      3: add_text($sformatf("%0d", $urandom()));
      4: begin
        // well past 32 bits
        big = 64'($urandom_range(1, 255));
        big = (big << 32) | 64'($urandom());
        add_text($sformatf("%0d", big));
      end
      5: begin
        big = 64'd4294967293 + 64'($urandom_range(0, 4));
        add_text($sformatf("%0d", big));
      end
      6: ;
      7: begin
        if ($urandom_range(0, 1)) add_text("-");
        else add_text("+");
        add_text($sformatf("%0d", $urandom_range(0, 99)));
      end
      8: add_text({$sformatf("%0d", $urandom_range(0, 9999)), " sec"});
      default: add_text({"000", $sformatf("%0d", $urandom_range(0, 99))});
    endcase
  endtask

  task automatic add_agent_line();
    if ($urandom_range(0, 4) == 0) add_text(" ");
    if ($urandom_range(0, 9) == 0) add_text("user-agent:");
    else add_text("User-agent:");
    add_blanks();
    case ($urandom_range(0, 7))
      0, 1, 2: add_agent_name(0);
      3: add_text("*");
      4: add_text("Spider");
      5: begin
        add_text("x");
        add_agent_name(0);
        add_text("/2.1");
      end
      6: add_agent_name(1);
      default: add_text("Fetcher*");
    endcase
    // both tags on one line now and then
    if ($urandom_range(0, 7) == 0) begin
      add_text(" Crawl-delay: ");
      add_number();
    end
  endtask

  task automatic add_delay_line();
    case ($urandom_range(0, 9))
      0: add_text("a:");
      1: add_text(" ");
      default: ;
    endcase
    if ($urandom_range(0, 11) == 0) add_text("Crawl-Delay:");
    else add_text("Crawl-delay:");
    add_blanks();
    add_number();
    if ($urandom_range(0, 3) == 0) add_blanks();
  endtask

  task automatic add_other_line();
    case ($urandom_range(0, 4))
      0: repeat ($urandom_range(0, 20)) file_bytes.push_back(8'($urandom_range(0, 255)));
      1: add_text("Disallow: /private");
      2: add_text("# see *");
      3: add_text("Sitemap: x");
      default: ;
    endcase
  endtask

  // Mostly well-formed files: agent line first, then a mix of lines
  task automatic build_file(input bit short_file);
    int unsigned lines;
    file_bytes.delete();
    if (short_file) begin
      repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      lines = $urandom_range(1, 3);
      for (int l = 0; l < lines; l++) begin
        if (l == 0 && $urandom_range(0, 6) != 0) begin
          add_agent_line();
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2: add_agent_line();
            3, 4, 5, 6: add_delay_line();
            default: add_other_line();
          endcase
        end
        if (l < lines - 1 || $urandom_range(0, 1)) begin
          if ($urandom_range(0, 3) == 0) file_bytes.push_back(CH_CR);
          file_bytes.push_back(CH_NL);
        end
      end
      if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_file();
    foreach (file_bytes[i])
      offer_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, '0);
  endtask

  // Agent settings walked phase by phase, extremes among them
  task automatic pick_agent(input int unsigned sel);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0] len;
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    if (sel >= 1 && sel <= 3) begin
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = 8'($urandom_range(33, 126));
        hi[8*k +: 8] = 8'($urandom_range(33, 126));
      end
    end
    case (sel)
      0: len = 5'd0;
      1: len = 5'($urandom_range(1, 6));
      2: len = 5'd16;
      3: len = 5'($urandom_range(17, 31));
      4: len = 5'($urandom_range(1, 16));
      5: begin
        lo = '1;
        hi = '1;
        len = 5'd16;
      end
      6: begin
        lo = '0;
        hi = '0;
        len = 5'd31;
      end
      default: len = 5'($urandom_range(0, 31));
    endcase
    write_agent(lo, hi, len);
  endtask

  // Return side: random or no idling per result, one long hold on request
  initial begin : receiver
    int unsigned wait_cycles;
    int unsigned taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        wait_cycles = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if ((taken / 12) % 2 == 1) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 19);
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      taken++;
    end
  end

  // Compare each returned delay with the oldest one waiting
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_delays.size() == 0) begin
        $display("%0t: delay %0d returned, expected none", $time, out_delay_seconds);
        mismatches++;
      end else if (pending_delays[0] !== out_delay_seconds) begin
        $display("%0t: delay mismatch, expected %0d, got %0d",
                 $time, pending_delays[0], out_delay_seconds);
        mismatches++;
        void'(pending_delays.pop_front());
      end else begin
        void'(pending_delays.pop_front());
      end
    end
  end

  typedef struct {
    bit          set_agent;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    string       body;
    logic [7:0]  last_byte;
    bit          known;
    logic [31:0] delay;
  } file_case_t;

  file_case_t cases [$];

  task automatic add_case(input bit set_agent, input logic [63:0] lo, input logic [63:0] hi,
                          input logic [4:0] len, input string body,
                          input logic [7:0] last_byte, input bit known,
                          input logic [31:0] delay);
    file_case_t c;
    c.set_agent = set_agent;
    c.lo = lo;
    c.hi = hi;
    c.len = len;
    c.body = body;
    c.last_byte = last_byte;
    c.known = known;
    c.delay = delay;
    cases.push_back(c);
  endtask

  initial begin : stimulus
    int unsigned files_done;
    int unsigned phase_no;
    clear_line();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files; first ones run on the reset agent setting (empty agent)
    add_case(1'b0, '0, '0, '0, "", 8'h00, 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0, "", 8'hFF, 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0, "", CH_NL, 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0, "User-agent:\nCrawl-delay:", "7", 1'b1, 32'd7);
    add_case(1'b0, '0, '0, '0, "User-agent: *\nCrawl-delay:\t\013\014\015 42", CH_NL, 1'b1,
             32'd42);
    add_case(1'b0, '0, '0, '0,
             "User-agent:*\nCrawl-delay: 4294967295\nCrawl-delay: 4294967296", CH_NL, 1'b1,
             32'hFFFF_FFFF);
    add_case(1'b0, '0, '0, '0,
             "User-agent:*\nCrawl-delay: -5\nCrawl-delay: +6\nCrawl-delay:",
             CH_NL, 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0, "User-agent:*\nUser-agent: x Crawl-delay: 9", CH_NL, 1'b1,
             32'd0);
    add_case(1'b0, '0, '0, '0, "User-agent:*\n\n\015\nCrawl-delay: 3\n\n", CH_NL, 1'b1,
             32'd3);
    add_case(1'b0, '0, '0, '0, "User-agent:*\nx: Crawl-delay: 8", CH_NL, 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0, "User-agent:*\nCrawl-delay:", "0", 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0,
             "Crawl-delay: 6\nUser-agent:*\nCrawl-delay:2\nUser-agent: a",
             CH_NL, 1'b0, '0);
    add_case(1'b1, "toB", '0, 5'd3, "User-agent: Bot\nCrawl-delay: 12", CH_NL, 1'b1,
             32'd12);
    add_case(1'b0, '0, '0, '0, "User-agent: Other\nCrawl-delay: 12", CH_NL, 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0, "User-agent: bot\nCrawl-delay: 5", CH_NL, 1'b1, 32'd0);
    add_case(1'b0, '0, '0, '0,
             "User-agent: *\nCrawl-delay: 5\nUser-agent: X\nCrawl-delay: 50",
             CH_NL, 1'b1, 32'd5);
    add_case(1'b1, "HGFEDCBA", "PONMLKJI", 5'd31,
             "User-agent:ABCDEFGHIJKLMNOP\nCrawl-delay:77", CH_NL, 1'b1, 32'd77);
    add_case(1'b0, '0, '0, '0, "User-agent:BCDEFGHIJKLMNOP\nCrawl-delay:77", CH_NL, 1'b1,
             32'd0);
    add_case(1'b1, '1, '1, 5'd16,
             "User-agent:\377\377\377\377\377\377\377\377\377\377\377\377\377\377\377\377",
             "\n", 1'b0, '0);
    add_case(1'b0, '0, '0, '0,
             "User-agent: \377\377\377\377\377\377\377\377\nCrawl-delay:3",
             "1", 1'b0, '0);
    add_case(1'b1, 64'h0A, '0, 5'd1, "User-agent: \nCrawl-delay: 4", CH_NL, 1'b1, 32'd0);
    add_case(1'b1, '0, '0, 5'd0, "User-agent: Any\nCrawl-delay: 9\nCrawl-delay: 15", CH_NL,
             1'b1, 32'd15);

    foreach (cases[r]) begin
      if (cases[r].set_agent) begin
        drain();
        write_agent(cases[r].lo, cases[r].hi, cases[r].len);
      end
      send_pace = $urandom_range(0, 2);
      for (int i = 0; i < cases[r].body.len(); i++)
        offer_byte(cases[r].body[i], 1'b0, 1'b0, '0);
      offer_byte(cases[r].last_byte, 1'b1, cases[r].known, cases[r].delay);
    end

    // Random files in phases, agent setting changed between phases
    bytes_sent = 0;
    files_done = 0;
    phase_no = 0;
    while (bytes_sent < RANDOM_BYTES || files_done < MIN_FILES || phase_no < MIN_PHASES) begin
      drain();
      pick_agent(phase_no < MIN_PHASES ? phase_no : $urandom_range(0, 7));
      if (phase_no == 2) begin
        // hold the return side off and keep offering short files back to back
        hold_request = 1'b1;
        send_pace = 0;
        repeat (30) begin
          build_file(1'b1);
          send_file();
          files_done++;
        end
        drain();
      end
      repeat (FILES_PER_PHASE) begin
        send_pace = $urandom_range(0, 2);
        build_file(1'b0);
        send_file();
        files_done++;
      end
      phase_no++;
    end

    drain();
    if (mismatches == 0 && pending_delays.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
